// File: sv/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared definitions for the biconnectivity check
// Holds default sizes, the register reset value and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Default graph capacity and the reset value of the vertex count register.
    localparam int MAX_VERTICES_DEF = 64;
    localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_edge;  // store the accepted edge in the matrix
        logic init;       // start a walk at vertex 0
        logic scan_rd;    // read the matrix bit of the current vertex and scan index
        logic skip;       // advance the scan index
        logic push;       // descend along a tree edge
        logic back_rd;    // read the depth of the scanned vertex
        logic back_upd;   // fold that depth into the low value, then advance
        logic pop_rd;     // leave the current vertex, fetch its parent frame
        logic pop_ld;     // load the parent frame as the current one
        logic res_ld;     // load the verdict into the output register
        logic clr_start;  // restart the matrix clearing sweep
        logic clr_step;   // clear one matrix bit
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;   // scan index reached the vertex count
        logic edge_hit;   // an edge to another vertex exists at the scan index
        logic w_visited;  // the scanned vertex was already reached
        logic w_parent;   // the scanned vertex is the tree parent
        logic top_zero;   // the current vertex is the root
        logic clr_last;   // the clearing sweep is at its final bit
        logic out_free;   // the output register can take a verdict
    } sts_t;

endpackage

// File: sv/bcc_ctrl.sv
// ----------------------------------------------------------------------------
// bcc_ctrl: walk sequencer
// State machine that loads edges, steps the depth-first walk one matrix bit
// at a time, hands the verdict to the output and sweeps the matrix clear.
// ----------------------------------------------------------------------------
module bcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          last_edge,
    output logic          in_stall,
    input  bcc_pkg::sts_t sts,
    output bcc_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_BACK_EV,
        ST_POP_LD,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;

    // Edges are taken only while no walk or clearing sweep is running.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.load_edge = 1'b1;
                    if (last_edge)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (sts.scan_end)
                begin
                    if (sts.top_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = ST_POP_LD;
                    end
                end
                else if (sts.edge_hit && !sts.w_visited)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else if (sts.edge_hit && !sts.w_parent)
                begin
                    cmd.back_rd = 1'b1;
                    state_next  = ST_BACK_EV;
                end
                else
                begin
                    cmd.skip   = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_BACK_EV:
            begin
                cmd.back_upd = 1'b1;
                state_next   = ST_SCAN_RD;
            end
            ST_POP_LD:
            begin
                cmd.pop_ld = 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.res_ld    = 1'b1;
                    cmd.clr_start = 1'b1;
                    state_next    = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts with a clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/bcc_dp.sv
// ----------------------------------------------------------------------------
// bcc_dp: walk datapath
// Adjacency bit memories, per-vertex depth memory, frame stack, current
// frame registers, verdict flags and the output register.
// ----------------------------------------------------------------------------
module bcc_dp #(
    parameter int MAX_VERTICES = bcc_pkg::MAX_VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [6:0]    cfg_write_data,
    input  logic [5:0]    vertex_a,
    input  logic [5:0]    vertex_b,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          biconnected,
    input  bcc_pkg::cmd_t cmd,
    output bcc_pkg::sts_t sts
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int NW        = $clog2(MAX_VERTICES + 1);
    localparam int AW        = 2 * VW;
    localparam int ADJ_DEPTH = 1 << AW;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [VW-1:0] par;
        logic [NW-1:0] scan;
        logic [VW-1:0] low;
    } frame_t;

    // Storage.
    logic               adj_a_mem [ADJ_DEPTH];
    logic               adj_b_mem [ADJ_DEPTH];
    logic [VW-1:0]      depth_mem [MAX_VERTICES];
    frame_t             stack_mem [MAX_VERTICES];

    logic [6:0]              nv_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VW-1:0]           cur_v_reg;
    logic [VW-1:0]           cur_par_reg;
    logic [NW-1:0]           cur_scan_reg;
    logic [VW-1:0]           cur_low_reg;
    logic [VW-1:0]           top_reg;
    logic [NW-1:0]           reached_reg;
    logic                    cut_reg;
    logic                    root_child_reg;
    logic [VW-1:0]           child_low_reg;
    logic [AW-1:0]           clr_cnt_reg;
    logic                    out_valid_reg;
    logic                    result_reg;
    logic                    rd_a_reg;
    logic                    rd_b_reg;
    logic [VW-1:0]           depth_rd_reg;
    frame_t                  frame_rd_reg;

    logic [NW-1:0] n_eff;
    logic          edge_ok;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;
    logic [VW-1:0] w_idx;
    logic [VW-1:0] top_m1;
    logic [VW-1:0] top_p1;
    logic          adj_we;
    logic [AW-1:0] adj_a_addr;
    logic [AW-1:0] adj_b_addr;
    logic          adj_wdata;

    // Effective vertex count: zero acts as one, large values are clamped.
    always_comb
    begin
        if (nv_reg == 7'd0)
        begin
            n_eff = NW'(1);
        end
        else if ({25'd0, nv_reg} > 32'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(nv_reg);
        end
    end

    // Edge filtering: both ends in range and distinct.
    assign edge_ok = ({26'd0, vertex_a} < 32'(n_eff)) && ({26'd0, vertex_b} < 32'(n_eff))
                     && (vertex_a != vertex_b);
    assign a_idx   = VW'(vertex_a);
    assign b_idx   = VW'(vertex_b);
    assign w_idx   = cur_scan_reg[VW-1:0];
    assign top_m1  = top_reg - VW'(1);
    assign top_p1  = top_reg + VW'(1);

    // Matrix write port: the clearing sweep or one edge, each memory one bit.
    always_comb
    begin
        if (cmd.clr_step)
        begin
            adj_we     = 1'b1;
            adj_a_addr = clr_cnt_reg;
            adj_b_addr = clr_cnt_reg;
            adj_wdata  = 1'b0;
        end
        else
        begin
            adj_we     = cmd.load_edge && edge_ok;
            adj_a_addr = {a_idx, b_idx};
            adj_b_addr = {b_idx, a_idx};
            adj_wdata  = 1'b1;
        end
    end

    // Adjacency memories; an edge bit is the OR of both halves.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_a_mem[adj_a_addr] <= adj_wdata;
        end
        if (cmd.scan_rd)
        begin
            rd_a_reg <= adj_a_mem[{cur_v_reg, w_idx}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_b_mem[adj_b_addr] <= adj_wdata;
        end
        if (cmd.scan_rd)
        begin
            rd_b_reg <= adj_b_mem[{cur_v_reg, w_idx}];
        end
    end

    // Depth memory: written when a vertex is reached, read for back edges.
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            depth_mem[0] <= '0;
        end
        else if (cmd.push)
        begin
            depth_mem[w_idx] <= top_p1;
        end
        if (cmd.back_rd)
        begin
            depth_rd_reg <= depth_mem[w_idx];
        end
    end

    // Frame stack holding the ancestors of the current vertex.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[top_reg] <= '{v: cur_v_reg, par: cur_par_reg,
                                    scan: cur_scan_reg + NW'(1), low: cur_low_reg};
        end
        if (cmd.pop_rd)
        begin
            frame_rd_reg <= stack_mem[top_m1];
        end
    end

    // Current frame, walk flags, configuration and output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg         <= bcc_pkg::NUM_VERTICES_RESET;
            visited_reg    <= '0;
            cur_v_reg      <= '0;
            cur_par_reg    <= '0;
            cur_scan_reg   <= '0;
            cur_low_reg    <= '0;
            top_reg        <= '0;
            reached_reg    <= '0;
            cut_reg        <= 1'b0;
            root_child_reg <= 1'b0;
            child_low_reg  <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            result_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                nv_reg <= cfg_write_data;
            end

            if (cmd.clr_start)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            if (cmd.init)
            begin
                visited_reg    <= MAX_VERTICES'(1);
                cur_v_reg      <= '0;
                cur_par_reg    <= '0;
                cur_scan_reg   <= '0;
                cur_low_reg    <= '0;
                top_reg        <= '0;
                reached_reg    <= NW'(1);
                cut_reg        <= 1'b0;
                root_child_reg <= 1'b0;
            end

            if (cmd.skip)
            begin
                cur_scan_reg <= cur_scan_reg + NW'(1);
            end

            // Tree edge: save the frame and descend.
            if (cmd.push)
            begin
                visited_reg[w_idx] <= 1'b1;
                reached_reg        <= reached_reg + NW'(1);
                cur_v_reg          <= w_idx;
                cur_par_reg        <= cur_v_reg;
                cur_scan_reg       <= '0;
                cur_low_reg        <= top_p1;
                top_reg            <= top_p1;
                if (top_reg == '0)
                begin
                    root_child_reg <= 1'b1;
                    if (root_child_reg)
                    begin
                        cut_reg <= 1'b1;
                    end
                end
            end

            // Back edge: lower the low value.
            if (cmd.back_upd)
            begin
                if (depth_rd_reg < cur_low_reg)
                begin
                    cur_low_reg <= depth_rd_reg;
                end
                cur_scan_reg <= cur_scan_reg + NW'(1);
            end

            // Leaving a vertex: a non-root parent is a cut vertex if the
            // subtree reaches no higher than the parent itself.
            if (cmd.pop_rd)
            begin
                child_low_reg <= cur_low_reg;
                top_reg       <= top_m1;
                if ((top_reg > VW'(1)) && (cur_low_reg >= top_m1))
                begin
                    cut_reg <= 1'b1;
                end
            end

            if (cmd.pop_ld)
            begin
                cur_v_reg    <= frame_rd_reg.v;
                cur_par_reg  <= frame_rd_reg.par;
                cur_scan_reg <= frame_rd_reg.scan;
                cur_low_reg  <= (child_low_reg < frame_rd_reg.low) ? child_low_reg
                                                                   : frame_rd_reg.low;
            end

            // Output register.
            if (cmd.res_ld)
            begin
                out_valid_reg <= 1'b1;
                result_reg    <= !cut_reg && (reached_reg == n_eff);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.scan_end  = (cur_scan_reg >= n_eff);
        sts.edge_hit  = (rd_a_reg || rd_b_reg) && (w_idx != cur_v_reg);
        sts.w_visited = visited_reg[w_idx];
        sts.w_parent  = (top_reg != '0) && (w_idx == cur_par_reg);
        sts.top_zero  = (top_reg == '0);
        sts.clr_last  = (clr_cnt_reg == {AW{1'b1}});
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign biconnected = result_reg;

endmodule

// File: sv/biconnectivity_check_core.sv
// ----------------------------------------------------------------------------
// biconnectivity_check_core: 2-vertex connectivity test of an edge list
// Loads undirected edges and, on the last one, reports whether the graph
// is biconnected, using a depth-first walk from vertex 0.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle while the block is idle, into a bit matrix. The
// transfer that carries last_edge starts the walk; the walk steps through
// matrix rows one bit at a time, reading each bit and then evaluating it, with
// an extra depth read and update for each back edge and, for each return to a
// parent, a close of the row and a reload of the parent frame. After the verdict
// transfer is queued, the matrix is swept clear one bit per cycle; the same
// sweep runs after reset. No edge is taken during the walk or the sweep. Edges
// with an end at or above the vertex count, self-loops and duplicates have no
// effect.
module biconnectivity_check_core #(
    parameter int MAX_VERTICES = bcc_pkg::MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [6:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    input  logic       last_edge,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       biconnected
);

    bcc_pkg::cmd_t cmd;
    bcc_pkg::sts_t sts;

    // Sequencer.
    bcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    bcc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .biconnected    (biconnected),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// File: tb/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker: verdict predictor and scoreboard for biconnectivity_check_core
// Watches register writes and both transfer channels, rebuilds the edge
// matrix, runs its own depth-first articulation test on each last edge and
// compares every verdict transfer against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module bcc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [6:0] cfg_write_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    input  logic       last_edge,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       biconnected,
    output int         fail_count,
    output int         verdicts_owed
);

    localparam int CAPACITY = bcc_pkg::MAX_VERTICES_DEF;

    logic [CAPACITY-1:0] edge_rows [CAPACITY];
    logic [6:0]          vertex_count;
    bit                  verdict_q [$];

    // Vertex count as the block uses it: zero acts as one, large values clamp.
    function automatic int used_count(logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (raw > CAPACITY)
            return CAPACITY;
        return int'(raw);
    endfunction

    // Depth-first walk from vertex 0 with an explicit stack of frames.
    function automatic bit walk_verdict(int n);
        int depth [CAPACITY];
        int low [CAPACITY];
        int frame_v [CAPACITY];
        int frame_scan [CAPACITY];
        bit seen [CAPACITY];
        int sp, top, v, par, w, root_kids, reached;
        bit cut, has_par;
        foreach (seen[i])
            seen[i] = 1'b0;
        seen[0] = 1'b1;
        depth[0] = 0;
        low[0] = 0;
        frame_v[0] = 0;
        frame_scan[0] = 0;
        sp = 1;
        root_kids = 0;
        reached = 1;
        cut = 1'b0;
        while (sp > 0)
        begin
            top = sp - 1;
            v = frame_v[top];
            has_par = (top > 0);
            par = has_par ? frame_v[top-1] : 0;
            w = frame_scan[top];
            while (w < n && !(w != v && edge_rows[v][w]))
                w++;
            if (w < n)
            begin
                frame_scan[top] = w + 1;
                if (!seen[w])
                begin
                    // A second tree child of the root makes the root a cut vertex.
                    if (top == 0)
                    begin
                        if (root_kids < 2)
                            root_kids++;
                        if (root_kids > 1)
                            cut = 1'b1;
                    end
                    seen[w] = 1'b1;
                    reached++;
                    depth[w] = depth[v] + 1;
                    low[w] = depth[w];
                    if (sp < CAPACITY)
                    begin
                        frame_v[sp] = w;
                        frame_scan[sp] = 0;
                        sp++;
                    end
                end
                else if (!(has_par && w == par))
                begin
                    if (depth[w] < low[v])
                        low[v] = depth[w];
                end
            end
            else
            begin
                // Return to the parent and fold the subtree low into it.
                sp--;
                if (has_par)
                begin
                    if (low[v] < low[par])
                        low[par] = low[v];
                    if (top > 1 && low[v] >= depth[par])
                        cut = 1'b1;
                end
            end
        end
        return !cut && reached == n;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    // Track the register, build the matrix and check verdict transfers.
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        bit want;
        if (!rst_n)
        begin
            foreach (edge_rows[i])
                edge_rows[i] = '0;
            vertex_count = bcc_pkg::NUM_VERTICES_RESET;
            verdict_q.delete();
            verdicts_owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("verdict %0b with none predicted", biconnected));
                else
                begin
                    want = verdict_q.pop_front();
                    if (biconnected !== want)
                        report_mismatch($sformatf("biconnected %b, predicted %0b",
                                                  biconnected, want));
                end
            end
            if (in_valid && !in_stall)
            begin
                n = used_count(vertex_count);
                if (vertex_a < n && vertex_b < n && vertex_a != vertex_b)
                begin
                    edge_rows[vertex_a][vertex_b] = 1'b1;
                    edge_rows[vertex_b][vertex_a] = 1'b1;
                end
                if (last_edge)
                begin
                    verdict_q.insert(verdict_q.size(), walk_verdict(n));
                    foreach (edge_rows[i])
                        edge_rows[i] = '0;
                end
            end
            if (cfg_write_en)
                vertex_count = cfg_write_data;
            verdicts_owed = verdict_q.size();
        end
    end

    initial
    begin
        fail_count = 0;
        verdicts_owed = 0;
    end

endmodule

// File: tb/tb_biconnectivity_check_core.sv
// ----------------------------------------------------------------------------
// tb_biconnectivity_check_core: testbench for the biconnectivity check
// Drives directed graphs for the corner cases, then random graphs under
// changing vertex counts and idle patterns; a checker predicts each verdict.
// ----------------------------------------------------------------------------
module tb_biconnectivity_check_core;

    localparam int HOLD_CYCLES  = 12000;
    localparam int SETTLE_WAIT  = 4300;
    localparam int STALL_LIMIT  = 150000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic [6:0] cfg_write_data;
    logic       in_valid;
    logic       in_stall;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
    logic       last_edge;
    logic       out_valid;
    logic       out_stall;
    logic       biconnected;
    int         fail_count;
    int         verdicts_owed;

    int send_idle;
    int recv_idle;
    bit hold_req;
    int edges_sent;
    int quiet_cycles;
    int cur_n;

    biconnectivity_check_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .last_edge      (last_edge),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .biconnected    (biconnected)
    );

    bcc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .last_edge      (last_edge),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .biconnected    (biconnected),
        .fail_count     (fail_count),
        .verdicts_owed  (verdicts_owed)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, or one long hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one edge and hold it until the transfer, then maybe idle.
    task automatic send_edge(int a, int b, bit last);
        in_valid  <= 1'b1;
        vertex_a  <= a[5:0];
        vertex_b  <= b[5:0];
        last_edge <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        edges_sent++;
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
    endtask

    // Stop offering, wait for every verdict and for the clearing sweep.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_count(int value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value[6:0];
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
        cur_n = (value == 0) ? 1 : (value > 64 ? 64 : value);
    endtask

    // One random graph over the current vertex count.
    task automatic send_graph();
        int ea [$];
        int eb [$];
        int kind, m, k, j, t;
        kind = $urandom_range(0, 4);
        case (kind)
            0, 1:
            begin
                // Ring with chords: mostly biconnected, sometimes one edge dropped.
                for (k = 0; k < cur_n; k++)
                begin
                    ea.insert(ea.size(), k);
                    eb.insert(eb.size(), (k + 1) % cur_n);
                end
                m = $urandom_range(0, 3);
                for (k = 0; k < m; k++)
                begin
                    ea.insert(ea.size(), $urandom_range(0, cur_n - 1));
                    eb.insert(eb.size(), $urandom_range(0, cur_n - 1));
                end
                if (kind == 1 && ea.size() > 1)
                begin
                    t = $urandom_range(0, ea.size() - 1);
                    ea.delete(t);
                    eb.delete(t);
                end
            end
            2:
            begin
                // Random tree.
                for (k = 1; k < cur_n; k++)
                begin
                    ea.insert(ea.size(), k);
                    eb.insert(eb.size(), $urandom_range(0, k - 1));
                end
            end
            default:
            begin
                m = $urandom_range(1, 2 * cur_n + 2);
                for (k = 0; k < m; k++)
                begin
                    ea.insert(ea.size(), $urandom_range(0, cur_n - 1));
                    eb.insert(eb.size(), $urandom_range(0, cur_n - 1));
                end
            end
        endcase
        // Noise across the whole field range, possibly ignored or duplicate.
        if ($urandom_range(0, 99) < 30)
        begin
            t = $urandom_range(0, ea.size());
            ea.insert(t, $urandom_range(0, 63));
            eb.insert(t, $urandom_range(0, 63));
        end
        if (ea.size() == 0)
        begin
            ea.insert(0, 0);
            eb.insert(0, 0);
        end
        // Shuffle, and swap endpoints at random.
        for (k = ea.size() - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = ea[k]; ea[k] = ea[j]; ea[j] = t;
            t = eb[k]; eb[k] = eb[j]; eb[j] = t;
        end
        for (k = 0; k < ea.size(); k++)
        begin
            if ($urandom_range(0, 1))
                send_edge(ea[k], eb[k], k == ea.size() - 1);
            else
                send_edge(eb[k], ea[k], k == ea.size() - 1);
        end
    endtask

    task automatic random_phase(int sidle, int ridle, int quota, bit pressure);
        int graphs;
        send_idle = sidle;
        recv_idle = ridle;
        graphs = 0;
        while (edges_sent < quota)
        begin
            if (graphs % 4 == 0)
            begin
                settle();
                if ($urandom_range(0, 9) == 0)
                    write_count(64);
                else
                    write_count($urandom_range(2, 12));
            end
            if (pressure && graphs == 1)
                hold_req = 1'b1;
            send_graph();
            graphs++;
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 7'd0;
        in_valid       = 1'b0;
        vertex_a       = 6'd0;
        vertex_b       = 6'd0;
        last_edge      = 1'b0;
        send_idle      = 0;
        recv_idle      = 0;
        hold_req       = 1'b0;
        edges_sent     = 0;
        quiet_cycles   = 0;
        cur_n          = 64;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Directed: single vertex, with an ignored edge at the top of the range.
        write_count(1);
        send_edge(63, 63, 1'b0);
        send_edge(0, 0, 1'b1);
        settle();
        // Two vertices joined by one edge.
        write_count(2);
        send_edge(0, 1, 1'b1);
        settle();
        // A count of zero acts as one.
        write_count(0);
        send_edge(5, 3, 1'b1);
        settle();
        // An oversized count clamps to the full matrix; a lone duplicate edge.
        write_count(127);
        send_edge(63, 0, 1'b0);
        send_edge(0, 63, 1'b1);
        settle();
        // Triangle with a self-loop and an out-of-range edge.
        write_count(3);
        send_edge(0, 1, 1'b0);
        send_edge(1, 1, 1'b0);
        send_edge(0, 40, 1'b0);
        send_edge(1, 2, 1'b0);
        send_edge(2, 0, 1'b1);
        settle();
        // Star: the root has several tree children.
        write_count(4);
        send_edge(0, 1, 1'b0);
        send_edge(0, 2, 1'b0);
        send_edge(3, 0, 1'b1);
        settle();
        // Path: an inner vertex is a cut vertex.
        send_edge(0, 1, 1'b0);
        send_edge(2, 1, 1'b0);
        send_edge(2, 3, 1'b1);
        settle();
        // Count lowered after the edges were loaded.
        write_count(5);
        send_edge(0, 1, 1'b0);
        send_edge(1, 2, 1'b0);
        send_edge(3, 4, 1'b0);
        send_edge(4, 0, 1'b0);
        in_valid <= 1'b0;
        repeat (10) @(posedge clk);
        write_count(3);
        send_edge(2, 0, 1'b1);

        // Random graphs under three idle patterns, with a long receiver hold-off.
        random_phase(18, 48, 190, 1'b0);
        random_phase(48, 18, 360, 1'b0);
        random_phase(0, 0, 520, 1'b1);

        settle();
        if (fail_count == 0 && verdicts_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
